[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while in reset
`define RSWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication in the next cycle, off while in reset
`define RSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition checked at every edge, reset included
`define RSWD_ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

`endif

[design/rswd_pkg.sv]
// Types and constants of the row split write descriptor generator
package rswd_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_ELEMENT_BYTES  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SRC_ROW_COLS   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_VALID_COLS     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PAGE_COLS      = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PAGES_PER_ROW  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_FIRST_PAGE_IDX = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_FIRST_PAGE_OFF = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_ROWS_PER_BLOCK = 3'd7;

    localparam logic [3:0]  RST_ELEMENT_BYTES  = 4'd2;
    localparam logic [13:0] RST_SRC_ROW_COLS   = 14'd32;
    localparam logic [13:0] RST_VALID_COLS     = 14'd32;
    localparam logic [13:0] RST_PAGE_COLS      = 14'd32;
    localparam logic [15:0] RST_PAGES_PER_ROW  = 16'd1;
    localparam logic [15:0] RST_FIRST_PAGE_IDX = 16'd0;
    localparam logic [12:0] RST_FIRST_PAGE_OFF = 13'd0;
    localparam logic [5:0]  RST_ROWS_PER_BLOCK = 6'd32;

    localparam int QueueDepth = 2;

    // configuration after clamping
    typedef struct packed {
        logic [3:0]  element_bytes;
        logic [13:0] src_row_cols;
        logic [13:0] valid_cols;
        logic [13:0] page_cols;
        logic [15:0] pages_per_row;
        logic [15:0] first_page_index;
        logic [12:0] first_page_col_offset;
        logic [5:0]  rows_per_block;
    } rswd_cfg_t;

    // per-row bases handed from front to back
    typedef struct packed {
        logic [20:0] src_offset;
        logic [31:0] page_id;
        logic [15:0] page_offset;
    } rswd_desc_t;

endpackage

[design/rswd_if.sv]
// Valid/ready channel interfaces for row requests and chunk descriptors
interface rswd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_index;
    logic [4:0]  row_in_block;

    modport source (output valid, output block_index, output row_in_block, input ready);
    modport sink (input valid, input block_index, input row_in_block, output ready);
endinterface

interface rswd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] src_offset;
    logic [31:0] page_id;
    logic [15:0] page_offset;
    logic [16:0] byte_count;
    logic        last;
    logic        overflow;

    modport source (output valid, output src_offset, output page_id, output page_offset,
                    output byte_count, output last, output overflow, input ready);
    modport sink (input valid, input src_offset, input page_id, input page_offset,
                  input byte_count, input last, input overflow, output ready);
endinterface

[design/row_split_write_descriptor_gen_top.sv]
// Top level of the row split write descriptor generator
// Each accepted row passes through the front end (accept, then three multiply
// stages for the source offset and the row's base page id) and is queued
// unless it has no valid columns; the back end loads a row from the queue and
// then emits one chunk per cycle into the output register while the output is
// not stalled, up to MAX_CHUNKS descriptors per row; a row with no valid
// columns emits none. The block does not enforce that registers are written
// through cfg_we/cfg_index/cfg_wdata only while idle; the user must keep to it.
module row_split_write_descriptor_gen_top #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rswd_in_if.sink                         rows,
    rswd_out_if.source                      chunks,
    input  logic                            cfg_we,
    input  logic [rswd_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [rswd_pkg::CfgDataW-1:0]   cfg_wdata
);

    logic [3:0]  eb_reg;
    logic [13:0] stride_reg;
    logic [13:0] valid_reg;
    logic [13:0] pcols_reg;
    logic [15:0] ppr_reg;
    logic [15:0] fpage_reg;
    logic [12:0] foff_reg;
    logic [5:0]  rpb_reg;

    rswd_pkg::rswd_cfg_t  cfg;
    rswd_pkg::rswd_desc_t push_data;
    rswd_pkg::rswd_desc_t rdata;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    logic [13:0]          pcols_eff;

    assign pcols_eff = (pcols_reg == 14'd0) ? 14'd1 : pcols_reg;

    always_comb
    begin
        cfg.element_bytes         = eb_reg;
        cfg.src_row_cols          = stride_reg;
        cfg.valid_cols            = valid_reg;
        cfg.page_cols             = pcols_eff;
        cfg.pages_per_row         = ppr_reg;
        cfg.first_page_index      = fpage_reg;
        cfg.first_page_col_offset = (14'(foff_reg) >= pcols_eff)
                                    ? 13'(pcols_eff - 14'd1) : foff_reg;
        cfg.rows_per_block        = (7'(rpb_reg) > 7'(MAX_ROWS))
                                    ? 6'(MAX_ROWS) : rpb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eb_reg     <= rswd_pkg::RST_ELEMENT_BYTES;
            stride_reg <= rswd_pkg::RST_SRC_ROW_COLS;
            valid_reg  <= rswd_pkg::RST_VALID_COLS;
            pcols_reg  <= rswd_pkg::RST_PAGE_COLS;
            ppr_reg    <= rswd_pkg::RST_PAGES_PER_ROW;
            fpage_reg  <= rswd_pkg::RST_FIRST_PAGE_IDX;
            foff_reg   <= rswd_pkg::RST_FIRST_PAGE_OFF;
            rpb_reg    <= rswd_pkg::RST_ROWS_PER_BLOCK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rswd_pkg::REG_ELEMENT_BYTES:  eb_reg     <= cfg_wdata[3:0];
                rswd_pkg::REG_SRC_ROW_COLS:   stride_reg <= cfg_wdata[13:0];
                rswd_pkg::REG_VALID_COLS:     valid_reg  <= cfg_wdata[13:0];
                rswd_pkg::REG_PAGE_COLS:      pcols_reg  <= cfg_wdata[13:0];
                rswd_pkg::REG_PAGES_PER_ROW:  ppr_reg    <= cfg_wdata;
                rswd_pkg::REG_FIRST_PAGE_IDX: fpage_reg  <= cfg_wdata;
                rswd_pkg::REG_FIRST_PAGE_OFF: foff_reg   <= cfg_wdata[12:0];
                rswd_pkg::REG_ROWS_PER_BLOCK: rpb_reg    <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    rswd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rswd_queue #(
        .DEPTH (rswd_pkg::QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .full  (full),
        .pop   (pop),
        .rdata (rdata),
        .empty (empty)
    );

    rswd_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pop    (pop),
        .rdata  (rdata),
        .empty  (empty),
        .chunks (chunks)
    );

endmodule

[design/rswd_front.sv]
// Front end: accepts a row and computes its source, page and offset bases
module rswd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    rswd_in_if.sink               rows,
    input  rswd_pkg::rswd_cfg_t   cfg,
    output logic                  push,
    output rswd_pkg::rswd_desc_t  push_data,
    input  logic                  full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_MUL3 = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [15:0] blk_reg;
    logic [4:0]  row_reg;
    logic [18:0] rs_reg;
    logic [21:0] br_reg;
    logic [15:0] poff_reg;
    logic [20:0] src_reg;
    logic [21:0] ridx_reg;
    logic [16:0] poff_full;

    assign rows.ready = (state_reg == S_IDLE);
    assign poff_full  = 17'(cfg.first_page_col_offset) * 17'(cfg.element_bytes);

    assign push_data.src_offset  = src_reg;
    assign push_data.page_offset = poff_reg;
    assign push_data.page_id     = 32'(ridx_reg) * 32'(cfg.pages_per_row)
                                   + 32'(cfg.first_page_index);
    assign push = (state_reg == S_MUL3) && !full && (cfg.valid_cols != 14'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rows.valid)
                    state_next = S_MUL1;
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_MUL3;
            S_MUL3:
            begin
                if (!full || cfg.valid_cols == 14'd0)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (rows.valid && rows.ready)
        begin
            blk_reg <= rows.block_index;
            row_reg <= rows.row_in_block;
        end
        if (state_reg == S_MUL1)
        begin
            rs_reg   <= 19'(row_reg) * 19'(cfg.src_row_cols);
            br_reg   <= 22'(blk_reg) * 22'(cfg.rows_per_block);
            poff_reg <= poff_full[15:0];
        end
        if (state_reg == S_MUL2)
        begin
            src_reg  <= 21'(rs_reg) * 21'(cfg.element_bytes);
            ridx_reg <= br_reg + 22'(row_reg);
        end
    end

endmodule

[design/rswd_queue.sv]
// Short descriptor queue between front and back
module rswd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rswd_pkg::rswd_desc_t  wdata,
    output logic                  full,
    input  logic                  pop,
    output rswd_pkg::rswd_desc_t  rdata,
    output logic                  empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    rswd_pkg::rswd_desc_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[design/rswd_back.sv]
// Back end: walks one row's columns and emits one chunk descriptor per cycle while the output is not stalled
module rswd_back #(
    parameter int MAX_CHUNKS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rswd_pkg::rswd_cfg_t   cfg,
    output logic                  pop,
    input  rswd_pkg::rswd_desc_t  rdata,
    input  logic                  empty,
    rswd_out_if.source            chunks
);

    localparam int CntW = (MAX_CHUNKS > 2) ? $clog2(MAX_CHUNKS) : 1;

    logic            active_reg;
    logic [13:0]     done_reg;
    logic [CntW-1:0] n_reg;
    logic [13:0]     room_reg;
    logic [20:0]     src_reg;
    logic [31:0]     page_reg;
    logic [15:0]     poff_reg;

    logic            ov_reg;
    logic [20:0]     o_src_reg;
    logic [31:0]     o_page_reg;
    logic [15:0]     o_poff_reg;
    logic [16:0]     o_bytes_reg;
    logic            o_last_reg;
    logic            o_ovf_reg;

    logic        out_free;
    logic        step;
    logic [13:0] left;
    logic [13:0] cols;
    logic [14:0] sum;
    logic        final_chunk;
    logic        cut;
    logic [17:0] bytes;

    assign out_free    = !ov_reg || chunks.ready;
    assign step        = active_reg && out_free;
    assign pop         = !active_reg && !empty;
    assign left        = cfg.valid_cols - done_reg;
    assign cols        = (left < room_reg) ? left : room_reg;
    assign sum         = 15'(done_reg) + 15'(cols);
    assign final_chunk = (sum >= 15'(cfg.valid_cols));
    assign cut         = !final_chunk && (n_reg == CntW'(MAX_CHUNKS - 1));
    assign bytes       = 18'(cols) * 18'(cfg.element_bytes);

    assign chunks.valid       = ov_reg;
    assign chunks.src_offset  = o_src_reg;
    assign chunks.page_id     = o_page_reg;
    assign chunks.page_offset = o_poff_reg;
    assign chunks.byte_count  = o_bytes_reg;
    assign chunks.last        = o_last_reg;
    assign chunks.overflow    = o_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
                active_reg <= 1'b1;
            else if (step && (final_chunk || cut))
                active_reg <= 1'b0;
            if (step)
                ov_reg <= 1'b1;
            else if (chunks.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            done_reg <= '0;
            n_reg    <= '0;
            room_reg <= cfg.page_cols - 14'(cfg.first_page_col_offset);
            src_reg  <= rdata.src_offset;
            page_reg <= rdata.page_id;
            poff_reg <= rdata.page_offset;
        end
        else if (step)
        begin
            done_reg <= sum[13:0];
            n_reg    <= n_reg + 1'b1;
            room_reg <= cfg.page_cols;
            src_reg  <= src_reg + 21'(bytes);
            page_reg <= page_reg + 32'd1;
            poff_reg <= '0;
        end
        if (step)
        begin
            o_src_reg   <= src_reg;
            o_page_reg  <= page_reg;
            o_poff_reg  <= poff_reg;
            o_bytes_reg <= bytes[16:0];
            o_last_reg  <= final_chunk || cut;
            o_ovf_reg   <= cut;
        end
    end

endmodule

[design/rswd_checker.sv]
// Port-level checks of the descriptor generator, bound to the top level
`include "assert_macros.svh"

module rswd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [20:0] src_offset,
    input logic [31:0] page_id,
    input logic [16:0] byte_count,
    input logic        last,
    input logic        overflow
);

    logic [70:0] payload;

    assign payload = {src_offset, page_id, byte_count, last};

    `RSWD_ASSERT_ALWAYS(a_reset_idle, clk, rst_n || (out_valid !== 1'b1))
    `RSWD_ASSERT_SAME(a_ovf_last, clk, rst_n, out_valid && overflow, last)
    `RSWD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind row_split_write_descriptor_gen_top rswd_checker u_rswd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (chunks.valid),
    .out_ready  (chunks.ready),
    .src_offset (chunks.src_offset),
    .page_id    (chunks.page_id),
    .byte_count (chunks.byte_count),
    .last       (chunks.last),
    .overflow   (chunks.overflow)
);

[verif/row_split_write_descriptor_gen_top_tb.sv]
// Testbench for the row split write descriptor generator: directed and random rows, predicted chunks
`timescale 1ns / 1ps

module row_split_write_descriptor_gen_top_tb;

    localparam int MAX_ROWS      = 32;
    localparam int MAX_CHUNKS    = 64;
    localparam int SETTLE_CYCLES = 32;

    typedef struct packed {
        logic [20:0] src_offset;
        logic [31:0] page_id;
        logic [15:0] page_offset;
        logic [16:0] byte_count;
        logic        last;
        logic        overflow;
    } chunk_desc_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rswd_pkg::CfgIdxW-1:0]  cfg_index;
    logic [rswd_pkg::CfgDataW-1:0] cfg_wdata;

    rswd_in_if  rows_if ();
    rswd_out_if chunks_if ();

    row_split_write_descriptor_gen_top #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows_if),
        .chunks    (chunks_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [15:0] cfg_regs [8];
    chunk_desc_t pending_chunks [$];
    int          error_count;
    bit          quiet_tx;
    bit          quiet_rx;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL row_split_write_descriptor_gen_top");
        $finish;
    end

    function automatic logic [15:0] reg_mask(logic [rswd_pkg::CfgIdxW-1:0] idx);
        case (idx)
            rswd_pkg::REG_ELEMENT_BYTES:  return 16'h000f;
            rswd_pkg::REG_SRC_ROW_COLS,
            rswd_pkg::REG_VALID_COLS,
            rswd_pkg::REG_PAGE_COLS:      return 16'h3fff;
            rswd_pkg::REG_FIRST_PAGE_OFF: return 16'h1fff;
            rswd_pkg::REG_ROWS_PER_BLOCK: return 16'h003f;
            default:                      return 16'hffff;
        endcase
    endfunction

    function automatic void predict_row_chunks(logic [15:0] blk, logic [4:0] row);
        longint unsigned eb, stride, valid, pcols, ppr, fpage, foff, rpb;
        longint unsigned done, room, src, page, poff, cols;
        int              n;
        bit              fin;
        bit              cut;
        chunk_desc_t     d;
        eb     = 64'(cfg_regs[rswd_pkg::REG_ELEMENT_BYTES]);
        stride = 64'(cfg_regs[rswd_pkg::REG_SRC_ROW_COLS]);
        valid  = 64'(cfg_regs[rswd_pkg::REG_VALID_COLS]);
        pcols  = 64'(cfg_regs[rswd_pkg::REG_PAGE_COLS]);
        ppr    = 64'(cfg_regs[rswd_pkg::REG_PAGES_PER_ROW]);
        fpage  = 64'(cfg_regs[rswd_pkg::REG_FIRST_PAGE_IDX]);
        foff   = 64'(cfg_regs[rswd_pkg::REG_FIRST_PAGE_OFF]);
        rpb    = 64'(cfg_regs[rswd_pkg::REG_ROWS_PER_BLOCK]);
        if (pcols == 0)
            pcols = 1;
        if (foff >= pcols)
            foff = pcols - 1;
        if (rpb > MAX_ROWS)
            rpb = MAX_ROWS;
        done = 0;
        n    = 0;
        src  = 64'(row) * stride * eb;
        page = (64'(blk) * rpb + 64'(row)) * ppr + fpage;
        room = pcols - foff;
        poff = foff * eb;
        while (done < valid && n < MAX_CHUNKS)
        begin
            cols = (valid - done < room) ? valid - done : room;
            fin  = (done + cols >= valid);
            cut  = !fin && (n == MAX_CHUNKS - 1);
            d.src_offset  = src[20:0];
            d.page_id     = page[31:0];
            d.page_offset = poff[15:0];
            d.byte_count  = 17'(cols * eb);
            d.last        = fin || cut;
            d.overflow    = cut;
            pending_chunks.push_back(d);
            done += cols;
            src  += cols * eb;
            page += 1;
            room  = pcols;
            poff  = 0;
            n++;
        end
    endfunction

    function automatic int tx_gap();
        int r;
        if (quiet_tx)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin : rx_ready
        int r;
        if (!rst_n)
        begin
            chunks_if.ready <= 1'b0;
            stall_left = 0;
        end
        else if (quiet_rx)
            chunks_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            chunks_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            chunks_if.ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20)
                stall_left = $urandom_range(1, 3);
            else if (r < 23)
                stall_left = $urandom_range(10, 30);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : chunk_check
        chunk_desc_t want;
        if (rst_n && chunks_if.valid && chunks_if.ready)
        begin
            if (pending_chunks.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual src_offset %0h page_id %0h",
                         $time, chunks_if.src_offset, chunks_if.page_id);
                error_count++;
            end
            else
            begin
                want = pending_chunks[0];
                pending_chunks.delete(0);
                check_field("src_offset", want.src_offset, chunks_if.src_offset);
                check_field("page_id", want.page_id, chunks_if.page_id);
                check_field("page_offset", want.page_offset, chunks_if.page_offset);
                check_field("byte_count", want.byte_count, chunks_if.byte_count);
                check_field("last", want.last, chunks_if.last);
                check_field("overflow", want.overflow, chunks_if.overflow);
            end
        end
    end

    task automatic send_row(logic [15:0] blk, logic [4:0] row);
        int gap;
        rows_if.valid        <= 1'b1;
        rows_if.block_index  <= blk;
        rows_if.row_in_block <= row;
        @(posedge clk);
        while (!rows_if.ready)
            @(posedge clk);
        predict_row_chunks(blk, row);
        gap = tx_gap();
        if (gap > 0)
        begin
            rows_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // rows with no chunks may still be in flight once the queue drains
    task automatic wait_for_idle();
        rows_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [rswd_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
        cfg_we        <= 1'b1;
        cfg_index     <= idx;
        cfg_wdata     <= val;
        cfg_regs[idx]  = val & reg_mask(idx);
        @(posedge clk);
    endtask

    task automatic program_regs(logic [15:0] eb, logic [15:0] stride, logic [15:0] valid,
                                logic [15:0] pcols, logic [15:0] ppr, logic [15:0] fpage,
                                logic [15:0] foff, logic [15:0] rpb);
        wait_for_idle();
        write_reg(rswd_pkg::REG_ELEMENT_BYTES, eb);
        write_reg(rswd_pkg::REG_SRC_ROW_COLS, stride);
        write_reg(rswd_pkg::REG_VALID_COLS, valid);
        write_reg(rswd_pkg::REG_PAGE_COLS, pcols);
        write_reg(rswd_pkg::REG_PAGES_PER_ROW, ppr);
        write_reg(rswd_pkg::REG_FIRST_PAGE_IDX, fpage);
        write_reg(rswd_pkg::REG_FIRST_PAGE_OFF, foff);
        write_reg(rswd_pkg::REG_ROWS_PER_BLOCK, rpb);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_row(16'd0, 5'd0);
        send_row(16'hffff, 5'd31);
        send_row(16'd5, 5'd17);
    endtask

    task automatic test_page_split();
        program_regs(16'd4, 16'd100, 16'd70, 16'd16, 16'd5, 16'd3, 16'd5, 16'd8);
        send_row(16'd0, 5'd0);
        send_row(16'd3, 5'd7);
        send_row(16'hffff, 5'd31);
    endtask

    task automatic test_zero_valid_cols();
        program_regs(16'd2, 16'd64, 16'd0, 16'd32, 16'd2, 16'd1, 16'd3, 16'd32);
        send_row(16'd1, 5'd1);
        send_row(16'hffff, 5'd31);
    endtask

    task automatic test_chunk_limit();
        // zero page width acts as one column: exactly at the limit, then one past it
        program_regs(16'd1, 16'd8, 16'd64, 16'd0, 16'd1, 16'd0, 16'd0, 16'd32);
        send_row(16'd2, 5'd3);
        program_regs(16'd1, 16'd8, 16'd65, 16'd0, 16'd1, 16'd0, 16'd0, 16'd32);
        send_row(16'd2, 5'd4);
        program_regs(16'd8, 16'd8192, 16'd8192, 16'd1, 16'd64, 16'd9, 16'd8191, 16'd32);
        send_row(16'd77, 5'd30);
    endtask

    task automatic test_offset_saturation();
        program_regs(16'd2, 16'd48, 16'd40, 16'd32, 16'd3, 16'd10, 16'h1fff, 16'd16);
        send_row(16'd4, 5'd2);
        program_regs(16'd2, 16'd48, 16'd40, 16'd32, 16'd3, 16'd10, 16'd31, 16'd16);
        send_row(16'd4, 5'd2);
    endtask

    task automatic test_rows_per_block();
        program_regs(16'd3, 16'd20, 16'd25, 16'd10, 16'd7, 16'd2, 16'd4, 16'd63);
        send_row(16'd1000, 5'd3);
        program_regs(16'd3, 16'd20, 16'd25, 16'd10, 16'd7, 16'd2, 16'd4, 16'd4);
        send_row(16'd2, 5'd31);
        send_row(16'd7, 5'd4);
        program_regs(16'd3, 16'd20, 16'd25, 16'd10, 16'd7, 16'd2, 16'd4, 16'd0);
        send_row(16'd9, 5'd5);
    endtask

    task automatic test_wide_results();
        quiet_rx = 1'b1;
        program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0,
                     16'hffff);
        send_row(16'hffff, 5'd31);
        send_row(16'hfffe, 5'd30);
        quiet_rx = 1'b0;
        program_regs(16'd0, 16'd33, 16'd100, 16'd30, 16'd2, 16'd5, 16'd29, 16'd32);
        send_row(16'd6, 5'd9);
    endtask

    task automatic test_random_rows();
        logic [15:0] eb, stride, valid, pcols, ppr, fpage, foff, rpb;
        int          pc;
        int          vc;
        int          r;
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase % 5 == 4)
            begin
                eb     = 16'($urandom);
                stride = 16'($urandom);
                valid  = 16'($urandom);
                pcols  = 16'($urandom);
                ppr    = 16'($urandom);
                fpage  = 16'($urandom);
                foff   = 16'($urandom);
                rpb    = 16'($urandom);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    pc = $urandom_range(1, 16);
                else if (r < 8)
                    pc = $urandom_range(17, 512);
                else
                    pc = $urandom_range(513, 8192);
                vc     = ($urandom_range(0, 9) == 0) ? 0
                       : $urandom_range(1, (pc * 6 > 8192) ? 8192 : pc * 6);
                eb     = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 15))
                                                     : 16'($urandom_range(1, 8));
                stride = 16'($urandom_range(1, 8192));
                valid  = 16'(vc);
                pcols  = 16'(pc);
                ppr    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 8))
                                                     : 16'($urandom_range(1, 65535));
                fpage  = 16'($urandom);
                foff   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8191))
                                                     : 16'($urandom_range(0, pc - 1));
                rpb    = 16'($urandom_range(1, 32));
            end
            program_regs(eb, stride, valid, pcols, ppr, fpage, foff, rpb);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 13; i++)
                send_row(16'($urandom), 5'($urandom));
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial
    begin
        rows_if.valid        = 1'b0;
        rows_if.block_index  = '0;
        rows_if.row_in_block = '0;
        cfg_we               = 1'b0;
        cfg_index            = rswd_pkg::REG_ELEMENT_BYTES;
        cfg_wdata            = '0;
        rst_n                = 1'b0;
        quiet_tx             = 1'b0;
        quiet_rx             = 1'b0;
        cfg_regs[rswd_pkg::REG_ELEMENT_BYTES]  = 16'(rswd_pkg::RST_ELEMENT_BYTES);
        cfg_regs[rswd_pkg::REG_SRC_ROW_COLS]   = 16'(rswd_pkg::RST_SRC_ROW_COLS);
        cfg_regs[rswd_pkg::REG_VALID_COLS]     = 16'(rswd_pkg::RST_VALID_COLS);
        cfg_regs[rswd_pkg::REG_PAGE_COLS]      = 16'(rswd_pkg::RST_PAGE_COLS);
        cfg_regs[rswd_pkg::REG_PAGES_PER_ROW]  = rswd_pkg::RST_PAGES_PER_ROW;
        cfg_regs[rswd_pkg::REG_FIRST_PAGE_IDX] = rswd_pkg::RST_FIRST_PAGE_IDX;
        cfg_regs[rswd_pkg::REG_FIRST_PAGE_OFF] = 16'(rswd_pkg::RST_FIRST_PAGE_OFF);
        cfg_regs[rswd_pkg::REG_ROWS_PER_BLOCK] = 16'(rswd_pkg::RST_ROWS_PER_BLOCK);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_page_split();
        test_zero_valid_cols();
        test_chunk_limit();
        test_offset_saturation();
        test_rows_per_block();
        test_wide_results();
        test_random_rows();

        wait_for_idle();
        if (error_count == 0)
            $display("PASS row_split_write_descriptor_gen_top");
        else
            $display("FAIL row_split_write_descriptor_gen_top");
        $finish;
    end

endmodule
